### src/assert_macros.svh
// Assertion helpers for the RTL.
// ASSERT_PROP checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### src/hsk_pkg.sv
package hsk_pkg;

  localparam int SLOT_COUNT = 6;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int KEY_W      = 8;
  localparam int OUT_W      = KEY_W * (SLOT_COUNT + 1);

  // modifier usages 0xE0..0xE7 share these top five bits
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef enum logic [1:0] {
    CMD_PRESS       = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_SEND        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_COMMIT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;        // latch input beat, reset scan
    logic mod_update;  // set or clear one modifier bit
    logic clear_all;   // empty the report
    logic scan_step;   // visit one slot
    logic commit;      // write pressed key into free slot
    logic send_load;   // copy report into output register
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic link_up;
    logic key_zero;
    logic key_mod;
    logic last_slot;
    logic changed;
    logic out_busy;
  } dp_stat_t;

endpackage

### src/hsk_controller.sv
module hsk_controller import hsk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!stat.link_up) begin
          state_next = ST_IDLE;
        end else begin
          unique case (stat.cmd) inside
            CMD_PRESS, CMD_RELEASE: begin
              if (stat.key_zero || stat.key_mod) state_next = ST_IDLE;
              else state_next = ST_SCAN;
            end
            CMD_RELEASE_ALL: state_next = ST_IDLE;
            CMD_SEND:        state_next = ST_SEND;
            default:         state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.last_slot) begin
          state_next = (stat.cmd == CMD_PRESS) ? ST_COMMIT : ST_IDLE;
        end
      end
      ST_COMMIT: state_next = ST_IDLE;
      ST_SEND: begin
        if (!stat.changed || !stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_DECODE: begin
        if (stat.link_up) begin
          if ((stat.cmd == CMD_PRESS || stat.cmd == CMD_RELEASE) &&
              !stat.key_zero && stat.key_mod) begin
            ctrl.mod_update = 1'b1;
          end
          if (stat.cmd == CMD_RELEASE_ALL) ctrl.clear_all = 1'b1;
        end
      end
      ST_SCAN:   ctrl.scan_step = 1'b1;
      ST_COMMIT: ctrl.commit    = 1'b1;
      ST_SEND:   ctrl.send_load = stat.changed && !stat.out_busy;
      default: begin
      end
    endcase
  end

endmodule

### src/hsk_datapath.sv
`include "assert_macros.svh"

module hsk_datapath import hsk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_ctrl_t             ctrl,
  output dp_stat_t             stat,
  input  logic [1:0]           in_cmd,
  input  logic [KEY_W-1:0]     in_key,
  input  logic                 in_link,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_data
);

  cmd_t                  cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic                  link_q;
  logic [KEY_W-1:0]      mods;
  logic [KEY_W-1:0]      slots [SLOT_COUNT];
  logic                  changed;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  found;
  logic                  free_ok;
  logic [SLOT_IDX_W-1:0] free_idx;

  logic [KEY_W-1:0] mod_mask;
  logic [KEY_W-1:0] cur_slot;
  logic             cur_match;
  logic             any_held;

  assign mod_mask  = KEY_W'(1) << key_q[2:0];
  assign cur_slot  = slots[idx];
  assign cur_match = (cur_slot == key_q);

  always_comb begin
    any_held = (mods != '0);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slots[i] != '0) any_held = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd_t'(in_cmd);
      key_q  <= in_key;
      link_q <= in_link;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx     <= '0;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (ctrl.scan_step) begin
      idx <= idx + SLOT_IDX_W'(1);
      if (cmd_q == CMD_PRESS) begin
        if (cur_match) found <= 1'b1;
        if (!free_ok && cur_slot == '0) begin
          free_ok  <= 1'b1;
          free_idx <= idx;
        end
      end
    end
  end

  // report state
  always_ff @(posedge clk) begin
    if (rst) begin
      mods    <= '0;
      changed <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) slots[i] <= '0;
    end else begin
      if (ctrl.mod_update) begin
        if (cmd_q == CMD_PRESS && (mods & mod_mask) == '0) begin
          mods    <= mods | mod_mask;
          changed <= 1'b1;
        end else if (cmd_q == CMD_RELEASE && (mods & mod_mask) != '0) begin
          mods    <= mods & ~mod_mask;
          changed <= 1'b1;
        end
      end
      if (ctrl.clear_all && any_held) begin
        mods    <= '0;
        changed <= 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) slots[i] <= '0;
      end
      if (ctrl.scan_step && cmd_q == CMD_RELEASE && cur_match) begin
        slots[idx] <= '0;
        changed    <= 1'b1;
      end
      if (ctrl.commit && !found && free_ok) begin
        slots[free_idx] <= key_q;
        changed         <= 1'b1;
      end
      if (ctrl.send_load) changed <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.send_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.send_load) begin
      out_data[KEY_W-1:0] <= mods;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        out_data[KEY_W*(i+1) +: KEY_W] <= slots[i];
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_q;
    stat.link_up   = link_q;
    stat.key_zero  = (key_q == '0);
    stat.key_mod   = (key_q[KEY_W-1:3] == MOD_PREFIX);
    stat.last_slot = (idx == SLOT_IDX_W'(SLOT_COUNT - 1));
    stat.changed   = changed;
    stat.out_busy  = out_valid;
  end

  `ASSERT_NEVER(a_no_overwrite, clk, rst, ctrl.send_load && out_valid, "report beat overwritten before taken")
  `ASSERT_PROP(a_send_clears, clk, rst, ctrl.send_load |=> !changed, "changed flag survived a send")
  `ASSERT_PROP(a_scan_cmd, clk, rst, ctrl.scan_step |-> (cmd_q == CMD_PRESS || cmd_q == CMD_RELEASE), "slot scan for wrong command")
  `ASSERT_PROP(a_mod_marks, clk, rst, (!$past(rst) && !$stable(mods)) |-> changed, "modifier change not marked")

endmodule

### src/hid_six_key_report_builder.sv
// HID boot keyboard report builder, six-key rollover.
// Input stream: one beat per key event. tuser carries the command (press,
// release, release all, send); tdata carries the key usage and the link flag.
// Output stream: one beat per report, emitted only by a send command that
// finds the report changed since the last send; other commands give no beat.
// Timing: s_axis_tready is high only while the controller is idle. A modifier
// press/release, release all, or any dropped event returns to idle straight
// from decode; a normal key press/release walks the six slots one per cycle.
// A send that finds the report changed loads it once the output register is free,
// and the report appears on m_axis as the controller returns to idle.
// The slot walk goes through the single slot comparator.
// Stalls: the report sits in an output register, so further events are taken
// while it waits; a send with a changed report waits until the last beat has gone.
// Reset (rst, synchronous): empties the report, clears the changed flag and
// drops any beat waiting on m_axis.
module hid_six_key_report_builder import hsk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] key_code, [8] link_up, [15:9] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [7:0] modifier_bits, [15:8] slot_key_0 ..
                                      // [55:48] slot_key_5
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  hsk_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  hsk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_cmd    (s_axis_tuser),
    .in_key    (s_axis_tdata[7:0]),
    .in_link   (s_axis_tdata[8]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### test/tb_hid_six_key_report_builder.sv
module tb_hid_six_key_report_builder;
  import hsk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // usage range of the eight modifier keys
  localparam logic [7:0] MOD_LO = 8'hE0;
  localparam logic [7:0] MOD_HI = 8'hE7;

  // receiver hold-off used to back the block up
  localparam int RX_HOLD_CYCLES = 400;
  // cycles to linger after the last report
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] key;
    logic       link_up;
  } key_evt_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;       // [7:0] key_code, [8] link_up, [15:9] zero
  logic [1:0]  s_axis_tuser = CMD_PRESS; // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;            // [7:0] modifier_bits, [15:8] slot_key_0 ..
                                        // [55:48] slot_key_5

  hid_six_key_report_builder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  key_evt_t    events_to_send[$];   // key events waiting for the driver
  logic [55:0] reports_due[$];      // reports the block owes us, oldest first
  int          mismatch_count = 0;

  // pacing, changed only on the falling edge by the stimulus process
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_asks = 0;

  // our own copy of the report being built
  logic [7:0] mods_held;
  logic [7:0] slot_keys [SLOT_COUNT];
  logic       report_dirty;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Advance the report copy by one accepted key event; a send that finds the
  // report dirty leaves one report in reports_due.
  task automatic track_report(input key_evt_t ev);
    logic [7:0]  mbit;
    logic        is_mod;
    logic        found;
    logic        any_held;
    int          free_idx;
    logic [55:0] rep;

    is_mod = (ev.key >= MOD_LO) && (ev.key <= MOD_HI);
    mbit   = 8'd1 << ev.key[2:0];
    if (ev.link_up) begin
      case (ev.cmd)
        CMD_PRESS: begin
          if (ev.key != 8'd0) begin
            if (is_mod) begin
              if ((mods_held & mbit) == 8'd0) begin
                mods_held    = mods_held | mbit;
                report_dirty = 1'b1;
              end
            end else begin
              found    = 1'b0;
              free_idx = SLOT_COUNT;
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_keys[i] == ev.key) found = 1'b1;
                if (free_idx == SLOT_COUNT && slot_keys[i] == 8'd0) free_idx = i;
              end
              // key already down, or table full: dropped
              if (!found && free_idx < SLOT_COUNT) begin
                slot_keys[free_idx] = ev.key;
                report_dirty        = 1'b1;
              end
            end
          end
        end
        CMD_RELEASE: begin
          if (ev.key != 8'd0) begin
            if (is_mod) begin
              if ((mods_held & mbit) != 8'd0) begin
                mods_held    = mods_held & ~mbit;
                report_dirty = 1'b1;
              end
            end else begin
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_keys[i] == ev.key) begin
                  slot_keys[i] = 8'd0;
                  report_dirty = 1'b1;
                end
              end
            end
          end
        end
        CMD_RELEASE_ALL: begin
          any_held = (mods_held != 8'd0);
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_keys[i] != 8'd0) any_held = 1'b1;
          end
          // empty report: the dirty flag keeps its value
          if (any_held) begin
            mods_held = 8'd0;
            for (int i = 0; i < SLOT_COUNT; i++) slot_keys[i] = 8'd0;
            report_dirty = 1'b1;
          end
        end
        default: begin
          if (report_dirty) begin
            report_dirty = 1'b0;
            rep[7:0]     = mods_held;
            for (int i = 0; i < SLOT_COUNT; i++) rep[8*(i+1) +: 8] = slot_keys[i];
            reports_due.push_back(rep);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued key events, holds a beat until it is taken and
  // runs the predictor on every accepted beat.
  // ---------------------------------------------------------------------------
  key_evt_t cur_evt;

  always @(posedge clk) begin : drive_events
    logic     go;
    key_evt_t nxt;

    if (rst) begin
      mods_held    = 8'd0;
      report_dirty = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) slot_keys[i] = 8'd0;
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_report(cur_evt);
      if (s_axis_tvalid && !s_axis_tready) begin
        // beat still waiting: keep it steady
      end else begin
        go = (events_to_send.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
        if (go) begin
          nxt           = events_to_send.pop_front();
          cur_evt       = nxt;
          s_axis_tuser  <= nxt.cmd;
          s_axis_tdata  <= {7'd0, nxt.link_up, nxt.key};
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_asks) begin
      rx_hold_seen  <= rx_hold_asks;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each report beat against the oldest report owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    logic [55:0] want;

    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("report beat with none owed, tdata %h", m_axis_tdata));
      end else begin
        want = reports_due.pop_front();
        for (int f = 0; f <= SLOT_COUNT; f++) begin
          if (m_axis_tdata[8*f +: 8] !== want[8*f +: 8]) begin
            flag_mismatch($sformatf("%s got %h want %h",
                (f == 0) ? "modifier_bits" : $sformatf("slot_key_%0d", f - 1),
                m_axis_tdata[8*f +: 8], want[8*f +: 8]));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_evt(input cmd_t cmd, input logic [7:0] key, input logic link_up);
    key_evt_t ev;
    ev.cmd     = cmd;
    ev.key     = key;
    ev.link_up = link_up;
    events_to_send.push_back(ev);
  endtask

  // Mostly plausible typing: a small key pool so repeats and a full table
  // come up often, some modifiers, the odd zero usage and wild code, and a
  // link that drops now and then.
  function automatic key_evt_t random_keystroke();
    key_evt_t ev;
    int       pick;

    pick = $urandom_range(99);
    if (pick < 40)      ev.cmd = CMD_PRESS;
    else if (pick < 70) ev.cmd = CMD_RELEASE;
    else if (pick < 75) ev.cmd = CMD_RELEASE_ALL;
    else                ev.cmd = CMD_SEND;

    pick = $urandom_range(99);
    if (pick < 55)      ev.key = 8'h04 + 8'($urandom_range(9));
    else if (pick < 75) ev.key = MOD_LO + 8'($urandom_range(7));
    else if (pick < 80) ev.key = 8'h00;
    else                ev.key = 8'($urandom_range(255));

    ev.link_up = ($urandom_range(99) < 92);
    return ev;
  endfunction

  task automatic queue_random(input int count);
    repeat (count) events_to_send.push_back(random_keystroke());
  endtask

  task automatic wait_sent();
    while (events_to_send.size() != 0 || s_axis_tvalid) @(negedge clk);
  endtask

  task automatic wait_reports();
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] k;

    while (rst) @(negedge clk);
    @(negedge clk);

    // directed: link down, zero usage, repeats, boundary codes, full table
    tx_idle_pct = 24;
    rx_idle_pct = 85;
    queue_evt(CMD_SEND,        8'h00, 1'b1);  // nothing changed since reset
    queue_evt(CMD_PRESS,       8'h00, 1'b1);  // zero usage is a no-op
    queue_evt(CMD_PRESS,       8'h04, 1'b0);  // link down
    queue_evt(CMD_SEND,        8'hFF, 1'b0);
    queue_evt(CMD_SEND,        8'h00, 1'b1);  // still clean
    queue_evt(CMD_PRESS,       8'hE0, 1'b1);
    queue_evt(CMD_PRESS,       8'hE7, 1'b1);
    queue_evt(CMD_PRESS,       8'hE7, 1'b1);  // modifier already held
    queue_evt(CMD_PRESS,       8'h04, 1'b1);
    queue_evt(CMD_PRESS,       8'h04, 1'b1);  // key already in a slot
    queue_evt(CMD_PRESS,       8'hFF, 1'b1);
    queue_evt(CMD_PRESS,       8'hDF, 1'b1);  // just below the modifiers
    queue_evt(CMD_PRESS,       8'hE8, 1'b1);  // just above the modifiers
    queue_evt(CMD_PRESS,       8'h05, 1'b1);
    queue_evt(CMD_PRESS,       8'h06, 1'b1);  // table now full
    queue_evt(CMD_PRESS,       8'h07, 1'b1);  // dropped
    queue_evt(CMD_SEND,        8'h00, 1'b1);
    queue_evt(CMD_SEND,        8'h00, 1'b1);  // no change since last send
    queue_evt(CMD_RELEASE,     8'h05, 1'b1);
    queue_evt(CMD_RELEASE,     8'h77, 1'b1);  // not held
    queue_evt(CMD_RELEASE,     8'hE0, 1'b1);
    queue_evt(CMD_RELEASE,     8'h00, 1'b1);
    queue_evt(CMD_RELEASE,     8'h04, 1'b0);  // link down
    queue_evt(CMD_PRESS,       8'h07, 1'b1);  // fills the hole left by 0x05
    queue_evt(CMD_SEND,        8'h00, 1'b1);
    queue_evt(CMD_RELEASE_ALL, 8'hFF, 1'b1);
    queue_evt(CMD_SEND,        8'h00, 1'b1);
    queue_evt(CMD_RELEASE_ALL, 8'h00, 1'b1);  // already empty
    queue_evt(CMD_SEND,        8'h00, 1'b1);

    // random, sender lightly gappy, receiver mostly stalled
    queue_random(660);
    wait_sent();

    // roles swapped
    tx_idle_pct = 85;
    rx_idle_pct = 24;
    queue_random(660);
    wait_sent();

    // no idling; hold the receiver off while press/send pairs pour in, so the
    // output register fills and the input side backs up. The table is emptied
    // first and the keys differ, so the early sends each owe a report.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_asks = rx_hold_asks + 1;
    queue_evt(CMD_RELEASE_ALL, 8'h00, 1'b1);
    k = 8'h10;
    repeat (12) begin
      queue_evt(CMD_PRESS, k, 1'b1);
      queue_evt(CMD_SEND, 8'($urandom_range(255)), 1'b1);
      k = k + 8'd1;
    end
    wait_sent();

    // sender stays quiet until every owed report has been taken
    wait_reports();
    queue_random(656);
    wait_sent();

    wait_reports();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
